// ----- rtl/rls_pkg.sv -----
// Shared types and constants of the run-length stack engine.
// No dependencies; imported by run_length_stack_engine.
`default_nettype none

package rls_pkg;

  // Number of entries in the run store.
  localparam int unsigned RUN_DEPTH = 256;
  localparam int unsigned IDX_W     = $clog2(RUN_DEPTH);
  localparam int unsigned PTR_W     = $clog2(RUN_DEPTH + 1);

  localparam int unsigned VALUE_W = 31;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned DATA_W  = 32;

  // APB register map: one 32-bit register.
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 3'd0;
  localparam logic [DATA_W-1:0] CAPACITY_RESET = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_TOP  = 2'd1,
    FUNC_POP  = 2'd2,
    FUNC_SIZE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_HALTED = 2'd3
  } status_e;

  typedef struct packed {
    func_e              func;
    logic [COUNT_W-1:0] amount;
    logic [VALUE_W-1:0] item_value;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] reply_data;
  } result_t;

  // One entry of the run store.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } run_t;

endpackage

`default_nettype wire

// ----- rtl/run_length_stack_engine.sv -----
// Run-length stack engine: top level with the run store memory and its sequencer.
// Depends on rls_pkg for types and constants.
`default_nettype none

// Push, size and any command after a halt finish without leaving idle: the result strobe
// follows the accepting edge and a new item may start in the same cycle.
// Top reads the run store synchronously in S_TOP before it answers, or
// answers from idle without a read when the stack is empty.
// Pop answers from idle when it fails or removes nothing; else it walks, in
// S_POP, the runs it touches, reading each run once through the single read
// port of the run store. busy is high while top or pop work.
// Results appear on done_o for exactly one cycle and cannot be held off.
// The run store needs no clearing after reset; the block is ready at once.
module run_length_stack_engine
  import rls_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire cmd_t                item_i,
  output logic                     done_o,
  output result_t                  result_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TOP  = 3'b010,
    S_POP  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [PTR_W-1:0]    ptr_q, ptr_d;
  logic [COUNT_W-1:0]  total_q, total_d;
  logic [COUNT_W-1:0]  left_q, left_d;
  logic                halted_q, halted_d;
  logic [DATA_W-1:0]   cap_q;
  logic                done_q, done_d;
  result_t             res_q, res_d;

  run_t                mem_q [RUN_DEPTH];
  run_t                rd_data_q;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  run_t                wr_data;

  logic                accept;
  logic [PTR_W-1:0]    ptr_dec;
  logic [PTR_W-1:0]    ptr_dec2;
  logic [COUNT_W:0]    push_sum;
  logic [COUNT_W-1:0]  left_rem;

  assign accept   = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);
  assign ptr_dec  = ptr_q - PTR_W'(1);
  assign ptr_dec2 = ptr_q - PTR_W'(2);
  assign push_sum = {1'b0, total_q} + {1'b0, item_i.amount};
  assign left_rem = left_q - rd_data_q.count;

  // Run store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    total_d  = total_q;
    left_d   = left_q;
    halted_d = halted_q;
    done_d   = 1'b0;
    res_d    = '{status: ST_OK, reply_data: '0};
    rd_en    = 1'b0;
    rd_addr  = ptr_dec[IDX_W-1:0];
    wr_en    = 1'b0;
    wr_addr  = ptr_q[IDX_W-1:0];
    wr_data  = '{value: item_i.item_value, count: item_i.amount};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (halted_q) begin
            done_d       = 1'b1;
            res_d.status = ST_HALTED;
          end else begin
            unique case (item_i.func)
              FUNC_PUSH: begin
                done_d = 1'b1;
                if (push_sum > {1'b0, cap_q}) begin
                  res_d.status = ST_FULL;
                  halted_d     = 1'b1;
                end else if (item_i.amount != '0) begin
                  if (ptr_q == PTR_W'(RUN_DEPTH)) begin
                    res_d.status = ST_FULL;
                    halted_d     = 1'b1;
                  end else begin
                    wr_en   = 1'b1;
                    ptr_d   = ptr_q + PTR_W'(1);
                    total_d = push_sum[COUNT_W-1:0];
                  end
                end
              end
              FUNC_TOP: begin
                if (total_q == '0 || ptr_q == '0) begin
                  done_d       = 1'b1;
                  res_d.status = ST_EMPTY;
                  halted_d     = 1'b1;
                end else begin
                  rd_en   = 1'b1;
                  state_d = S_TOP;
                end
              end
              FUNC_POP: begin
                if (item_i.amount > total_q) begin
                  done_d       = 1'b1;
                  res_d.status = ST_EMPTY;
                  halted_d     = 1'b1;
                end else begin
                  total_d = total_q - item_i.amount;
                  if (item_i.amount == '0 || ptr_q == '0) begin
                    done_d = 1'b1;
                  end else begin
                    left_d  = item_i.amount;
                    rd_en   = 1'b1;
                    state_d = S_POP;
                  end
                end
              end
              FUNC_SIZE: begin
                done_d           = 1'b1;
                res_d.reply_data = total_q;
              end
              default: begin
                done_d = 1'b1;
              end
            endcase
          end
        end
      end
      S_TOP: begin
        done_d           = 1'b1;
        res_d.reply_data = {{(DATA_W - VALUE_W){1'b0}}, rd_data_q.value};
        state_d          = S_IDLE;
      end
      S_POP: begin
        // The top run is in rd_data_q; either shorten it or drop it whole.
        if (rd_data_q.count > left_q) begin
          wr_en         = 1'b1;
          wr_addr       = ptr_dec[IDX_W-1:0];
          wr_data.value = rd_data_q.value;
          wr_data.count = rd_data_q.count - left_q;
          done_d        = 1'b1;
          state_d       = S_IDLE;
        end else begin
          ptr_d  = ptr_dec;
          left_d = left_rem;
          if (left_rem == '0 || ptr_dec == '0) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_dec2[IDX_W-1:0];
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ptr_q    <= '0;
      total_q  <= '0;
      halted_q <= 1'b0;
      done_q   <= 1'b0;
      cap_q    <= CAPACITY_RESET;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      total_q  <= total_d;
      halted_q <= halted_d;
      done_q   <= done_d;
      if (psel && penable && pwrite && (paddr == ADDR_CAPACITY)) begin
        cap_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    res_q  <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;
  assign prdata   = (paddr == ADDR_CAPACITY) ? cap_q : '0;
  assign pready   = 1'b1;

  // The run pointer never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_W'(RUN_DEPTH))
    else $error("run pointer beyond store depth");

  // Once halted, the block stays halted until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared without reset");

  // The pop walk only runs while at least one run is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> (ptr_q != '0))
    else $error("pop walk with no runs held");

  // An item taken while halted answers halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && $past(halted_q)) |-> (res_q.status == ST_HALTED))
    else $error("halted block gave a status other than halted");

  // An error status always halts the block at the same edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_q.status == ST_FULL || res_q.status == ST_EMPTY)) |-> halted_q)
    else $error("error reported without halting");

endmodule

`default_nettype wire
